FILE: design/rsa_pkg.sv
package rsa_pkg;

  // request field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned RowIdW  = 10;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PageW   = 11;
  localparam int unsigned OffsetW = 8;
  localparam int unsigned CountW  = 11;
  localparam int unsigned CfgW    = 9;

  // command codes
  localparam logic [CmdW-1:0] CMD_APPEND = 3'd0;
  localparam logic [CmdW-1:0] CMD_ERASE  = 3'd1;
  localparam logic [CmdW-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CmdW-1:0] CMD_REVIVE = 3'd3;
  localparam logic [CmdW-1:0] CMD_UPSERT = 3'd4;
  localparam logic [CmdW-1:0] CMD_GET    = 3'd5;

  // status codes
  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_REJECT = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL   = 2'd2;

  // page size after reset
  localparam int unsigned RppReset = 64;

endpackage

FILE: design/row_slot_allocator.sv
// Row-id slot allocator for a paged row store. A request (cmd_i, row_id_i) is
// taken at a clock edge where start is high and busy is low; exactly one result
// follows, shown for a single cycle with done_o high. There is no back-pressure:
// the receiver must take every result in the cycle it appears. Slots are created
// in id order, slot n sitting on page n/rows_per_page+1 at offset
// n mod rows_per_page; erased ids go onto a last-in first-out free stack.
// Erase, update, get, append that opens a new slot, upsert that opens or
// updates a slot, and every rejected or table-full request read the slot table
// on capture and give the result from the look state; append that reuses a free
// id passes through a pop state (a second slot table read for the popped id).
// Revive, and upsert on a dead id, walks the free stack through one compare unit,
// one entry per cycle, then closes the gap one entry per cycle. The next
// request can be taken in the cycle the result is shown. No clearing pass is
// needed after reset: the tables are only read below the slot count or stack
// depth. rows_per_page may be written via cfg_we_i while idle; it is ignored
// once any slot exists.
module row_slot_allocator #(
  parameter int unsigned MAX_ROWS          = 1024,
  parameter int unsigned MAX_ROWS_PER_PAGE = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request side
  input  logic                               start,
  output logic                               busy,
  input  logic [rsa_pkg::CmdW-1:0]           cmd_i,
  input  logic [rsa_pkg::RowIdW-1:0]         row_id_i,
  // result side
  output logic                               done_o,
  output logic [rsa_pkg::StatusW-1:0]        status_o,
  output logic [rsa_pkg::RowIdW-1:0]         slot_id_o,
  output logic [rsa_pkg::PageW-1:0]          page_number_o,
  output logic [rsa_pkg::OffsetW-1:0]        page_offset_o,
  output logic [rsa_pkg::CountW-1:0]         live_rows_o,
  output logic [rsa_pkg::CountW-1:0]         slots_used_o,
  // page size register
  input  logic                               cfg_we_i,
  input  logic [rsa_pkg::CfgW-1:0]           cfg_wdata_i
);

  // widths derived from the table size and page size range
  localparam int unsigned RppMax = (MAX_ROWS_PER_PAGE > rsa_pkg::RppReset) ?
                                   MAX_ROWS_PER_PAGE : rsa_pkg::RppReset;
  localparam int unsigned IdxW   = $clog2(MAX_ROWS);
  localparam int unsigned CntW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned PgW    = $clog2(MAX_ROWS + 2);
  localparam int unsigned OffW   = $clog2(RppMax);
  localparam int unsigned RppW   = $clog2(RppMax + 1);
  localparam int unsigned SlotW  = 1 + PgW + OffW;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [rsa_pkg::CmdW-1:0]      cmd_q;
  logic [rsa_pkg::RowIdW-1:0]    id_q;
  logic [IdxW-1:0]               ptr_q, ptr_d;
  logic [CntW-1:0]               depth_q, depth_d;
  logic [CntW-1:0]               total_q, total_d;
  logic [CntW-1:0]               live_q, live_d;
  logic [PgW-1:0]                npage_q, npage_d;
  logic [OffW-1:0]               noff_q, noff_d;
  logic [RppW-1:0]               rpp_q;

  // slot table: {live, page, offset}; free stack of ids
  logic [SlotW-1:0]              slot_mem [MAX_ROWS];
  logic [IdxW-1:0]               stk_mem  [MAX_ROWS];
  logic [SlotW-1:0]              slot_rd_q;
  logic [IdxW-1:0]               stk_rd_q;

  logic                          slot_we, slot_re, stk_we;
  logic [IdxW-1:0]               slot_waddr, slot_raddr, stk_waddr, stk_raddr;
  logic [SlotW-1:0]              slot_wdata;
  logic [IdxW-1:0]               stk_wdata;

  // result staging
  logic                          emit;
  logic [rsa_pkg::StatusW-1:0]   e_status;
  logic [rsa_pkg::RowIdW-1:0]    e_id;
  logic [PgW-1:0]                e_page;
  logic [OffW-1:0]               e_off;

  // decoded view of the slot entry read at request time or for a popped id
  logic                          s_live;
  logic [PgW-1:0]                s_page;
  logic [OffW-1:0]               s_off;
  logic                          known, live, full, at_next;
  logic [IdxW-1:0]               sidx;
  logic [rsa_pkg::CmdW-1:0]      ecmd;
  logic [rsa_pkg::CfgW-1:0]      cfg_nz;

  assign s_live  = slot_rd_q[SlotW-1];
  assign s_page  = slot_rd_q[SlotW-2 -: PgW];
  assign s_off   = slot_rd_q[OffW-1:0];
  assign sidx    = IdxW'(id_q);
  assign known   = 32'(id_q) < 32'(total_q);
  assign live    = known && s_live;
  assign full    = 32'(total_q) >= MAX_ROWS;
  assign at_next = 32'(id_q) == 32'(total_q);
  assign busy    = (state_q != S_IDLE);

  // page size write: zero reads as one, saturate at the maximum
  assign cfg_nz  = (cfg_wdata_i == '0) ? rsa_pkg::CfgW'(1) : cfg_wdata_i;

  // upsert on a known id behaves as update or revive
  always_comb begin
    ecmd = cmd_q;
    if (cmd_q == rsa_pkg::CMD_UPSERT && known) begin
      ecmd = live ? rsa_pkg::CMD_UPDATE : rsa_pkg::CMD_REVIVE;
    end
  end

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    depth_d    = depth_q;
    total_d    = total_q;
    live_d     = live_q;
    npage_d    = npage_q;
    noff_d     = noff_q;
    slot_we    = 1'b0;
    slot_waddr = sidx;
    slot_wdata = {1'b1, s_page, s_off};
    slot_re    = 1'b0;
    slot_raddr = IdxW'(row_id_i);
    stk_we     = 1'b0;
    stk_waddr  = ptr_q;
    stk_wdata  = stk_rd_q;
    stk_raddr  = IdxW'(depth_q - CntW'(1));
    emit       = 1'b0;
    e_status   = rsa_pkg::ST_REJECT;
    e_id       = id_q;
    e_page     = '0;
    e_off      = '0;

    case (state_q)
      S_IDLE: begin
        // read the target slot and the stack top in parallel
        if (start) begin
          slot_re = 1'b1;
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        case (ecmd)
          rsa_pkg::CMD_APPEND, rsa_pkg::CMD_UPSERT: begin
            if (ecmd == rsa_pkg::CMD_APPEND && depth_q != '0) begin
              // reuse newest free id, fetch its slot entry
              emit       = 1'b0;
              depth_d    = depth_q - CntW'(1);
              ptr_d      = stk_rd_q;
              slot_re    = 1'b1;
              slot_raddr = stk_rd_q;
              state_d    = S_POP;
            end else if (ecmd == rsa_pkg::CMD_UPSERT && !at_next) begin
              e_status = rsa_pkg::ST_REJECT;
            end else if (full) begin
              e_status = rsa_pkg::ST_FULL;
              e_id     = (ecmd == rsa_pkg::CMD_APPEND) ? '0 : id_q;
            end else begin
              // open a new slot at the end of the table
              slot_we    = 1'b1;
              slot_waddr = IdxW'(total_q);
              slot_wdata = {1'b1, npage_q, noff_q};
              total_d    = total_q + CntW'(1);
              live_d     = live_q + CntW'(1);
              if (32'(noff_q) + 1 >= 32'(rpp_q)) begin
                noff_d  = '0;
                npage_d = npage_q + PgW'(1);
              end else begin
                noff_d  = noff_q + OffW'(1);
              end
              e_status = rsa_pkg::ST_OK;
              e_id     = rsa_pkg::RowIdW'(total_q);
              e_page   = npage_q;
              e_off    = noff_q;
            end
          end
          rsa_pkg::CMD_ERASE: begin
            if (live) begin
              slot_we    = 1'b1;
              slot_wdata = {1'b0, s_page, s_off};
              if (32'(depth_q) < MAX_ROWS) begin
                stk_we    = 1'b1;
                stk_waddr = IdxW'(depth_q);
                stk_wdata = sidx;
                depth_d   = depth_q + CntW'(1);
              end
              live_d   = live_q - CntW'(1);
              e_status = rsa_pkg::ST_OK;
              e_page   = s_page;
              e_off    = s_off;
            end
          end
          rsa_pkg::CMD_UPDATE, rsa_pkg::CMD_GET: begin
            if (live) begin
              e_status = rsa_pkg::ST_OK;
              e_page   = s_page;
              e_off    = s_off;
            end
          end
          rsa_pkg::CMD_REVIVE: begin
            if (known && !live && depth_q != '0) begin
              // start the stack walk from the bottom
              emit      = 1'b0;
              stk_raddr = '0;
              ptr_d     = '0;
              state_d   = S_SCAN;
            end
          end
          default: begin
            e_status = rsa_pkg::ST_REJECT;
          end
        endcase
      end

      S_POP: begin
        slot_we    = 1'b1;
        slot_waddr = ptr_q;
        live_d     = live_q + CntW'(1);
        emit       = 1'b1;
        e_status   = rsa_pkg::ST_OK;
        e_id       = rsa_pkg::RowIdW'(ptr_q);
        e_page     = s_page;
        e_off      = s_off;
        state_d    = S_IDLE;
      end

      S_SCAN: begin
        // stk_rd_q holds the entry at ptr_q
        stk_raddr = IdxW'(32'(ptr_q) + 1);
        if (stk_rd_q == sidx) begin
          if (32'(ptr_q) + 1 < 32'(depth_q)) begin
            state_d = S_SHIFT;
          end else begin
            depth_d  = depth_q - CntW'(1);
            slot_we  = 1'b1;
            live_d   = live_q + CntW'(1);
            emit     = 1'b1;
            e_status = rsa_pkg::ST_OK;
            e_page   = s_page;
            e_off    = s_off;
            state_d  = S_IDLE;
          end
        end else if (32'(ptr_q) + 1 < 32'(depth_q)) begin
          ptr_d = IdxW'(32'(ptr_q) + 1);
        end else begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_SHIFT: begin
        // move entry ptr_q+1 down to ptr_q, prefetch ptr_q+2
        stk_we    = 1'b1;
        stk_waddr = ptr_q;
        stk_wdata = stk_rd_q;
        stk_raddr = IdxW'(32'(ptr_q) + 2);
        ptr_d     = IdxW'(32'(ptr_q) + 1);
        if (32'(ptr_q) + 2 >= 32'(depth_q)) begin
          depth_d  = depth_q - CntW'(1);
          slot_we  = 1'b1;
          live_d   = live_q + CntW'(1);
          emit     = 1'b1;
          e_status = rsa_pkg::ST_OK;
          e_page   = s_page;
          e_off    = s_off;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      depth_q <= '0;
      total_q <= '0;
      live_q  <= '0;
      npage_q <= PgW'(1);
      noff_q  <= '0;
      rpp_q   <= RppW'(rsa_pkg::RppReset);
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      depth_q <= depth_d;
      total_q <= total_d;
      live_q  <= live_d;
      npage_q <= npage_d;
      noff_q  <= noff_d;
      done_o  <= emit;
      if (cfg_we_i && total_q == '0) begin
        if (32'(cfg_nz) > MAX_ROWS_PER_PAGE) begin
          rpp_q <= RppW'(MAX_ROWS_PER_PAGE);
        end else begin
          rpp_q <= RppW'(cfg_nz);
        end
      end
    end
  end

  // request capture and result registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
      id_q  <= row_id_i;
    end
    if (emit) begin
      status_o      <= e_status;
      slot_id_o     <= e_id;
      page_number_o <= rsa_pkg::PageW'(e_page);
      page_offset_o <= rsa_pkg::OffsetW'(e_off);
      live_rows_o   <= rsa_pkg::CountW'(live_d);
      slots_used_o  <= rsa_pkg::CountW'(total_d);
    end
  end

  // slot table
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  // free stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

endmodule
